// File: rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [7:0] NO_SEXTET = 8'h80;
  localparam logic [7:0] CHAR_PAD  = 8'h3D;

  // one unit of work for the back end: up to three bytes taken from the top of triple
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbytes;
    logic        last;
    logic [1:0]  status;
  } job_t;

  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    logic [7:0] s;
    s = NO_SEXTET;
    priority if (c >= 8'h41 && c <= 8'h5A) s = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) s = c - 8'h61 + 8'h1A;
    else if (c >= 8'h30 && c <= 8'h39) s = c - 8'h30 + 8'h34;
    else if (c == 8'h2B) s = 8'h3E;
    else if (c == 8'h2F) s = 8'h3F;
    else if (c == CHAR_PAD) s = 8'h00;
    else s = NO_SEXTET;
    return s;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// File: rtl/core/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       char_in,
  input  logic             end_of_message,
  output logic             push,
  output b64d_pkg::job_t   job
);

  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] pend_triple_r, pend_triple_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [1:0]  pend_pad_r, pend_pad_nxt;
  logic        cur_pad_r, cur_pad_nxt;
  logic        seen_r, seen_nxt;
  logic        discard_r, discard_nxt;

  logic [7:0]  sext;
  logic        pad;
  logic        job_valid;

  function automatic b64d_pkg::job_t finish_job(
    input logic        seen,
    input logic [1:0]  pos,
    input logic        pv,
    input logic [23:0] triple,
    input logic [1:0]  pads
  );
    b64d_pkg::job_t j;
    j.triple = 24'd0;
    j.nbytes = 2'd1;
    j.last   = 1'b1;
    j.status = b64d_pkg::ST_OK;
    priority if (!seen || (pos == 2'd0 && !pv)) begin
      j.status = b64d_pkg::ST_EMPTY;
    end else if (pos != 2'd0) begin
      j.status = b64d_pkg::ST_LENGTH;
    end else begin
      j.triple = triple;
      j.nbytes = 2'd3 - {1'b0, pads[1]} - {1'b0, pads[0]};
    end
    return j;
  endfunction

  assign sext = b64d_pkg::sextet_of(char_in);
  assign pad  = (char_in == b64d_pkg::CHAR_PAD);

  always_comb begin
    accum_nxt       = accum_r;
    pos_nxt         = pos_r;
    pend_triple_nxt = pend_triple_r;
    pend_valid_nxt  = pend_valid_r;
    pend_pad_nxt    = pend_pad_r;
    cur_pad_nxt     = cur_pad_r;
    seen_nxt        = seen_r;
    discard_nxt     = discard_r;
    job_valid       = 1'b0;
    job.triple      = 24'd0;
    job.nbytes      = 2'd1;
    job.last        = 1'b1;
    job.status      = b64d_pkg::ST_OK;

    if (discard_r) begin
      if (end_of_message) discard_nxt = 1'b0;
    end else if (b64d_pkg::is_blank(char_in)) begin
      if (end_of_message) begin
        job_valid = 1'b1;
        job = finish_job(seen_r, pos_r, pend_valid_r, pend_triple_r, pend_pad_r);
        accum_nxt = '0; pos_nxt = '0; pend_triple_nxt = '0; pend_valid_nxt = 1'b0;
        pend_pad_nxt = '0; cur_pad_nxt = 1'b0; seen_nxt = 1'b0;
      end
    end else if (sext == b64d_pkg::NO_SEXTET) begin
      job_valid  = 1'b1;
      job.status = b64d_pkg::ST_INVALID;
      accum_nxt = '0; pos_nxt = '0; pend_triple_nxt = '0; pend_valid_nxt = 1'b0;
      pend_pad_nxt = '0; cur_pad_nxt = 1'b0; seen_nxt = 1'b0;
      discard_nxt = !end_of_message;
    end else begin
      seen_nxt = 1'b1;
      if (pos_r == 2'd3) begin
        pend_triple_nxt = {accum_r, sext[5:0]};
        pend_pad_nxt    = {cur_pad_r, pad};
        pend_valid_nxt  = 1'b1;
        accum_nxt       = '0;
        cur_pad_nxt     = 1'b0;
        pos_nxt         = 2'd0;
      end else begin
        if (pos_r == 2'd2) cur_pad_nxt = pad;
        accum_nxt      = {accum_r[11:0], sext[5:0]};
        pos_nxt        = pos_r + 2'd1;
        pend_valid_nxt = 1'b0;
      end
      if (end_of_message) begin
        job_valid = 1'b1;
        job = finish_job(1'b1, pos_nxt, pend_valid_nxt, pend_triple_nxt, pend_pad_nxt);
        accum_nxt = '0; pos_nxt = '0; pend_triple_nxt = '0; pend_valid_nxt = 1'b0;
        pend_pad_nxt = '0; cur_pad_nxt = 1'b0; seen_nxt = 1'b0;
      end else if (pend_valid_r) begin
        // the held-back quartet is not the last one, release all three bytes
        job_valid  = 1'b1;
        job.triple = pend_triple_r;
        job.nbytes = 2'd3;
        job.last   = 1'b0;
      end
    end
  end

  assign push = accept && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      pos_r         <= '0;
      pend_triple_r <= '0;
      pend_valid_r  <= 1'b0;
      pend_pad_r    <= '0;
      cur_pad_r     <= 1'b0;
      seen_r        <= 1'b0;
      discard_r     <= 1'b0;
    end else if (accept) begin
      accum_r       <= accum_nxt;
      pos_r         <= pos_nxt;
      pend_triple_r <= pend_triple_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_pad_r    <= pend_pad_nxt;
      cur_pad_r     <= cur_pad_nxt;
      seen_r        <= seen_nxt;
      discard_r     <= discard_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.last |=> pos_r == 2'd0 && !pend_valid_r && !seen_r)
    else $error("state not cleared after final job");

  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && discard_r |-> !push)
    else $error("job produced while discarding");

  a_pos_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 2'd0 || pend_valid_r) |-> seen_r)
    else $error("quartet progress without any character");

  a_flush_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !job.last |-> job.nbytes == 2'd3 && job.status == b64d_pkg::ST_OK)
    else $error("released quartet not a full triple");
`endif

endmodule

// File: rtl/core/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64d_pkg::job_t   push_job,
  input  logic             pop,
  output b64d_pkg::job_t   head_job,
  output logic             not_empty,
  output logic             full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64d_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));
  assign head_job  = mem[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      unique case ({push && !full, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  b64d_pkg::job_t   head_job,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic             out_final_byte,
  output logic [1:0]       out_status
);

  b64d_pkg::job_t job_r;
  logic           busy_r;
  logic [1:0]     idx_r;
  logic           out_valid_r;
  logic [7:0]     data_r;
  logic           final_r;
  logic [1:0]     status_r;

  logic           load;
  logic           last_byte;
  logic [7:0]     cur_byte;
  logic           take;

  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign last_byte = (idx_r == job_r.nbytes - 2'd1);
  assign take      = !busy_r || (load && last_byte);
  assign pop       = take && head_valid;

  always_comb begin
    unique case (idx_r)
      2'd0:    cur_byte = job_r.triple[23:16];
      2'd1:    cur_byte = job_r.triple[15:8];
      2'd2:    cur_byte = job_r.triple[7:0];
      default: cur_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= head_valid;
        idx_r  <= '0;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head_job;
    if (load) begin
      data_r   <= cur_byte;
      final_r  <= job_r.last && last_byte;
      status_r <= job_r.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = data_r;
  assign out_final_byte = final_r;
  assign out_status     = status_r;

endmodule

// File: rtl/core/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming base64 decoder, one character per transfer at up to one transfer per clock.
// The front end classifies each character and builds quartets; a completed quartet is
// held until the next base64 character shows it is not the last one, then its three
// bytes go into a small job queue (QUEUE_DEPTH entries). The back end drains one byte per
// clock while out_stall is low, through an output register, so in_stall rises only when the
// queue fills, which an unstalled output never causes since four characters yield at most
// three bytes. Errors (invalid character, length not a multiple of four, empty message)
// come out as a single result with final_byte set and a zero data byte; after an invalid
// character the rest of the message is dropped up to the end mark.

module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_final_byte,
  output logic [1:0] out_status
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           not_empty;
  logic           full;
  b64d_pkg::job_t push_job;
  b64d_pkg::job_t head_job;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  b64d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .char_in        (in_char_in),
    .end_of_message (in_end_of_message),
    .push           (push),
    .job            (push_job)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (not_empty),
    .full      (full)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .head_valid     (not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_final_byte (out_final_byte),
    .out_status     (out_status)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_byte_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_final_byte;
  logic [1:0] out_status;

  base64_stream_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_in(in_char_in),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data_byte(out_data_byte),
    .out_final_byte(out_final_byte),
    .out_status(out_status)
  );

  // decoder state as seen by the predictor
  logic [17:0] acc;
  logic [1:0]  qpos;
  logic [23:0] held;
  logic        held_ok;
  logic [1:0]  held_pads;
  logic        third_pad;
  logic        seen_any;
  logic        discarding;

  out_byte_t expected_out[$];

  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int in_stall_cycles = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit sender_gaps = 1'b0;
  bit stall_on = 1'b0;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit char_to_sextet(input logic [7:0] c, output logic [5:0] s);
    s = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) s = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) s = 6'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) s = 6'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) s = 6'd62;
    else if (c == 8'h2F) s = 6'd63;
    else if (c == b64d_pkg::CHAR_PAD) s = 6'd0;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_state();
    acc = '0;
    qpos = '0;
    held = '0;
    held_ok = 1'b0;
    held_pads = '0;
    third_pad = 1'b0;
    seen_any = 1'b0;
    discarding = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic l, input logic [1:0] st);
    expected_out.push_back('{data: d, last: l, status: st});
  endfunction

  function automatic void close_message();
    int n;
    if (!seen_any || (qpos == 2'd0 && !held_ok)) begin
      push_byte(8'h00, 1'b1, b64d_pkg::ST_EMPTY);
    end else if (qpos != 2'd0) begin
      push_byte(8'h00, 1'b1, b64d_pkg::ST_LENGTH);
    end else begin
      // each pad among the last two characters drops one byte
      n = 3 - int'(held_pads[0]) - int'(held_pads[1]);
      for (int k = 0; k < n; k++)
        push_byte(held[23 - 8 * k -: 8], (k == n - 1), b64d_pkg::ST_OK);
    end
    clear_state();
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eom);
    logic [5:0]  s;
    logic        pad;
    logic        flush_now;
    logic [23:0] flush_triple;
    if (discarding) begin
      if (eom) clear_state();
      return;
    end
    if (is_space(c)) begin
      if (eom) close_message();
      return;
    end
    if (!char_to_sextet(c, s)) begin
      push_byte(8'h00, 1'b1, b64d_pkg::ST_INVALID);
      clear_state();
      if (!eom) discarding = 1'b1;
      return;
    end
    seen_any = 1'b1;
    pad = (c == b64d_pkg::CHAR_PAD);
    flush_now = held_ok;
    flush_triple = held;
    held_ok = 1'b0;
    if (qpos == 2'd3) begin
      held = {acc, s};
      held_pads = {third_pad, pad};
      held_ok = 1'b1;
      acc = '0;
      third_pad = 1'b0;
      qpos = 2'd0;
    end else begin
      if (qpos == 2'd2) third_pad = pad;
      acc = {acc[11:0], s};
      qpos = qpos + 2'd1;
    end
    if (eom) begin
      close_message();
      return;
    end
    if (flush_now)
      for (int k = 0; k < 3; k++)
        push_byte(flush_triple[23 - 8 * k -: 8], 1'b0, b64d_pkg::ST_OK);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_end_of_message <= eom;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_cycles++;
    end while (in_stall);
    decode_char(c, eom);
    items_sent++;
  endtask

  task automatic send_text(input string txt, input bit end_mark);
    for (int i = 0; i < txt.len(); i++)
      send_char(txt[i], end_mark && (i == txt.len() - 1));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_alpha();
    int r;
    r = $urandom_range(0, 64);
    if (r < 26) return 8'(32'h41 + r);
    if (r < 52) return 8'(32'h61 + r - 26);
    if (r < 62) return 8'(32'h30 + r - 52);
    if (r == 62) return 8'h2B;
    if (r == 63) return 8'h2F;
    return b64d_pkg::CHAR_PAD;
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'h20 : 8'(r);
  endfunction

  function automatic logic [7:0] random_bad();
    logic [7:0] c;
    logic [5:0] s;
    do c = 8'($urandom_range(0, 255));
    while (is_space(c) || char_to_sextet(c, s));
    return c;
  endfunction

  // mostly well-formed messages, some with bad length, bad characters or no content
  task automatic send_random_message();
    logic [7:0] msg[$];
    int kind;
    int nq;
    int pads;
    int last;
    bit tail_blank;
    kind = $urandom_range(0, 99);
    nq = $urandom_range(1, 4);
    for (int k = 0; k < 4 * nq; k++) msg.push_back(random_alpha());
    last = msg.size() - 1;
    pads = $urandom_range(0, 2);
    if (pads > 0) msg[last] = b64d_pkg::CHAR_PAD;
    if (pads > 1) msg[last - 1] = b64d_pkg::CHAR_PAD;
    if (kind < 10) begin
      if ($urandom_range(0, 1)) void'(msg.pop_back());
      else msg.push_back(random_alpha());
    end else if (kind < 20) begin
      msg[$urandom_range(0, msg.size() - 1)] = random_bad();
    end else if (kind < 25) begin
      msg.delete();
    end
    tail_blank = ($urandom_range(0, 9) == 0) || (msg.size() == 0);
    for (int k = 0; k < msg.size(); k++) begin
      if ($urandom_range(0, 9) == 0) send_char(random_blank(), 1'b0);
      send_char(msg[k], !tail_blank && (k == msg.size() - 1));
    end
    if (tail_blank) send_char(random_blank(), 1'b1);
  endtask

  task automatic test_directed();
    sender_gaps = 1'b0;
    stall_on = 1'b0;
    send_char(8'h20, 1'b1);
    send_text("Az+/", 1'b0);
    send_char(8'h09, 1'b1);
    send_text("Zaz90/==", 1'b1);
    send_text("TW", 1'b0);
    send_char(8'h0B, 1'b0);
    send_text("E=", 1'b1);
    send_text("A=", 1'b1);
    // invalid character at the start of a message, rest is dropped up to the end mark
    send_char(8'hFF, 1'b0);
    send_text("AB", 1'b0);
    send_char(8'h0D, 1'b0);
    send_text("C", 1'b1);
    send_char(8'h00, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_messages();
    int target;
    target = items_sent + 140;
    stall_on = 1'b1;
    while (items_sent < target) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_random_message();
    end
    wait_for_results();
  endtask

  task automatic test_input_backpressure();
    sender_gaps = 1'b0;
    stall_on = 1'b0;
    hold_cycles = 120;
    for (int k = 0; k < 48; k++)
      send_char(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)),
                k == 47);
    wait_for_results();
  endtask

  task automatic test_random_bytes();
    sender_gaps = 1'b1;
    stall_on = 1'b1;
    for (int k = 0; k < 60; k++)
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    send_char(8'h20, 1'b1);
    wait_for_results();
  endtask

  // receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin : receiver_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 39);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : result_checker
    out_byte_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        status_seen[out_status]++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result data=%02h final=%0b status=%0d",
                                    out_data_byte, out_final_byte, out_status));
        end else begin
          want = expected_out.pop_front();
          if (out_data_byte !== want.data)
            report_mismatch($sformatf("data_byte %02h, wanted %02h",
                                      out_data_byte, want.data));
          if (out_final_byte !== want.last)
            report_mismatch($sformatf("final_byte %0b, wanted %0b",
                                      out_final_byte, want.last));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", out_status, want.status));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 idle, expected_out.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clear_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_messages();
    test_input_backpressure();
    test_random_bytes();
    repeat (12) @(posedge clk);
    $display("covered %0d characters and %0d results: %0d ok, %0d invalid, %0d length, %0d empty",
             items_sent, results_seen,
             status_seen[b64d_pkg::ST_OK], status_seen[b64d_pkg::ST_INVALID],
             status_seen[b64d_pkg::ST_LENGTH], status_seen[b64d_pkg::ST_EMPTY]);
    $display("input held off for %0d cycles while the output was blocked", in_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
